// File: hdl/fixed_point_ray_march_assert.svh
// Assertion macros for the fixed-point ray marcher.
// Used by the top level only; the macros sample on clock and skip reset.
`ifndef FIXED_POINT_RAY_MARCH_ASSERT_SVH
`define FIXED_POINT_RAY_MARCH_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FPRM_ASSERT_SAME(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("fprm assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define FPRM_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("fprm assertion failed");

`endif

// File: hdl/fprm_pkg.sv
// Shared constants and types for the fixed-point ray marcher.
// Used by the controller, the datapath and the top level; depends on nothing.
package fprm_pkg;

   localparam int MAX_STEPS = 31;
   localparam int STEP_W = $clog2(MAX_STEPS + 1);
   localparam int SL_W = 5;

   localparam int DIR_W = 16;
   localparam int TRIG_W = 14;
   localparam int COORD_W = 32;
   localparam int FRAC_BITS = 12;
   localparam int PROD_W = DIR_W + TRIG_W;
   localparam int RSUM_W = PROD_W + 1;
   localparam int RDIR_W = RSUM_W - FRAC_BITS;
   localparam int DIST_W = 17;

   localparam logic [DIST_W:0] DIST_BIAS = 18'h05000;
   localparam logic [DIST_W:0] HIT_LIMIT = 18'h00200;

   localparam logic [TRIG_W-1:0] ROT_COS_RESET = 14'd4096;

   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_ROT_SIN = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROT_COS = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_X = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_Y = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_Z = 3'd4;

   typedef struct packed {
      logic capture;
      logic rotate;
      logic measure;
      logic advance;
      logic rsp_load;
   } cmd_type;

   typedef struct packed {
      logic left_zero;
      logic hit;
   } status_type;

endpackage

// File: hdl/fprm_datapath.sv
// Datapath of the fixed-point ray marcher: configuration registers, rotation,
// distance estimate and position update. Depends on fprm_pkg.
module fprm_datapath
   import fprm_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_we,
   input  logic [CSR_IDX_W-1:0]         csr_index,
   input  logic [COORD_W-1:0]           csr_wdata,
   input  logic signed [DIR_W-1:0]      req_dir_x,
   input  logic signed [DIR_W-1:0]      req_dir_y,
   input  logic signed [DIR_W-1:0]      req_dir_z,
   input  cmd_type                      cmd,
   output status_type                   status,
   output logic [SL_W-1:0]              rsp_steps_left
);

   logic signed [TRIG_W-1:0]  rot_sin_ff;
   logic signed [TRIG_W-1:0]  rot_cos_ff;
   logic [COORD_W-1:0]        origin_x_ff;
   logic [COORD_W-1:0]        origin_y_ff;
   logic [COORD_W-1:0]        origin_z_ff;

   logic signed [PROD_W-1:0]  prod_xc_ff;
   logic signed [PROD_W-1:0]  prod_zs_ff;
   logic signed [PROD_W-1:0]  prod_zc_ff;
   logic signed [PROD_W-1:0]  prod_xs_ff;

   logic signed [RDIR_W-1:0]  dir_x_ff;
   logic signed [DIR_W-1:0]   dir_y_ff;
   logic signed [RDIR_W-1:0]  dir_z_ff;

   logic [COORD_W-1:0]        pos_x_ff;
   logic [COORD_W-1:0]        pos_y_ff;
   logic [COORD_W-1:0]        pos_z_ff;
   logic [DIST_W-1:0]         dist_ff;
   logic [STEP_W-1:0]         left_ff;
   logic [SL_W-1:0]           rsp_steps_left_ff;

   logic signed [RSUM_W-1:0]  rot_x_sum;
   logic signed [RSUM_W-1:0]  rot_z_sum;
   logic [15:0]               tx;
   logic [15:0]               ty;
   logic [15:0]               tz;
   logic [DIST_W-1:0]         tsum;
   logic [DIST_W-1:0]         tor;
   logic signed [DIST_W:0]    dist_est;
   logic signed [RDIR_W+DIST_W:0] step_x;
   logic signed [DIR_W+DIST_W:0]  step_y;
   logic signed [RDIR_W+DIST_W:0] step_z;

   always_ff @(posedge clock) begin
      if (reset) begin
         rot_sin_ff  <= '0;
         rot_cos_ff  <= ROT_COS_RESET;
         origin_x_ff <= '0;
         origin_y_ff <= '0;
         origin_z_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_ROT_SIN:  rot_sin_ff  <= csr_wdata[TRIG_W-1:0];
            CSR_ROT_COS:  rot_cos_ff  <= csr_wdata[TRIG_W-1:0];
            CSR_ORIGIN_X: origin_x_ff <= csr_wdata;
            CSR_ORIGIN_Y: origin_y_ff <= csr_wdata;
            CSR_ORIGIN_Z: origin_z_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign rot_x_sum = RSUM_W'(prod_xc_ff) + RSUM_W'(prod_zs_ff);
   assign rot_z_sum = RSUM_W'(prod_zc_ff) - RSUM_W'(prod_xs_ff);

   assign tx   = pos_x_ff[31:16] ^ {16{pos_x_ff[31]}};
   assign ty   = pos_y_ff[31:16] ^ {16{pos_y_ff[31]}};
   assign tz   = pos_z_ff[31:16] ^ {16{pos_z_ff[31]}};
   assign tsum = {1'b0, ty} + {1'b0, tz};
   assign tor  = {1'b0, tx} | tsum;
   assign dist_est = $signed({1'b0, tor}) - $signed(DIST_BIAS);

   assign status.left_zero = (left_ff == '0);
   assign status.hit       = (dist_est < $signed(HIT_LIMIT));

   assign step_x = dir_x_ff * $signed({1'b0, dist_ff});
   assign step_y = dir_y_ff * $signed({1'b0, dist_ff});
   assign step_z = dir_z_ff * $signed({1'b0, dist_ff});

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         prod_xc_ff <= req_dir_x * rot_cos_ff;
         prod_zs_ff <= req_dir_z * rot_sin_ff;
         prod_zc_ff <= req_dir_z * rot_cos_ff;
         prod_xs_ff <= req_dir_x * rot_sin_ff;
         dir_y_ff   <= req_dir_y;
      end
      if (cmd.rotate) begin
         dir_x_ff <= rot_x_sum[RSUM_W-1:FRAC_BITS];
         dir_z_ff <= rot_z_sum[RSUM_W-1:FRAC_BITS];
         pos_x_ff <= origin_x_ff;
         pos_y_ff <= origin_y_ff;
         pos_z_ff <= origin_z_ff;
         left_ff  <= STEP_W'(MAX_STEPS);
      end
      if (cmd.measure) begin
         dist_ff <= dist_est[DIST_W-1:0];
      end
      if (cmd.advance) begin
         pos_x_ff <= pos_x_ff + step_x[COORD_W-1:0];
         pos_y_ff <= pos_y_ff + step_y[COORD_W-1:0];
         pos_z_ff <= pos_z_ff + step_z[COORD_W-1:0];
         left_ff  <= left_ff - 1'b1;
      end
      if (cmd.rsp_load) begin
         rsp_steps_left_ff <= SL_W'(left_ff);
      end
   end

   assign rsp_steps_left = rsp_steps_left_ff;

endmodule

// File: hdl/fprm_ctrl.sv
// Controller of the fixed-point ray marcher: sequences rotation, the march
// loop and the result handoff. Depends on fprm_pkg.
module fprm_ctrl
   import fprm_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROTATE,
      ST_MEASURE,
      ST_ADVANCE,
      ST_FINISH
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_ROTATE;
            end
         end
         ST_ROTATE: begin
            cmd.rotate = 1'b1;
            state_in   = ST_MEASURE;
         end
         ST_MEASURE: begin
            cmd.measure = 1'b1;
            if (status.left_zero || status.hit) begin
               state_in = ST_FINISH;
            end else begin
               state_in = ST_ADVANCE;
            end
         end
         ST_ADVANCE: begin
            cmd.advance = 1'b1;
            state_in    = ST_MEASURE;
         end
         ST_FINISH: begin
            if (out_free) begin
               cmd.rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// File: hdl/fixed_point_ray_march.sv
// Fixed-point ray marcher. Each request transaction carries one ray direction,
// which is rotated about the Y axis and marched from the configured origin; the
// response transaction returns the march steps left at the surface hit, or 0.
// While a ray is marched, the loop alternates a measure state, which forms the
// distance estimate, and an advance state, which applies one multiply-add per
// coordinate. A new request is taken once the previous result has moved to the
// output register, even while that result still waits to be taken. Configuration
// writes are taken in every cycle.
// Depends on fprm_pkg, fprm_ctrl, fprm_datapath and the assertion macro header.
`include "fixed_point_ray_march_assert.svh"

module fixed_point_ray_march
   import fprm_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic signed [DIR_W-1:0] req_dir_x,
   input  logic signed [DIR_W-1:0] req_dir_y,
   input  logic signed [DIR_W-1:0] req_dir_z,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [SL_W-1:0]         rsp_steps_left,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [COORD_W-1:0]      csr_wdata
);

   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   fprm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   fprm_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_valid && csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_dir_x      (req_dir_x),
      .req_dir_y      (req_dir_y),
      .req_dir_z      (req_dir_z),
      .cmd            (cmd),
      .status         (status),
      .rsp_steps_left (rsp_steps_left)
   );

   `FPRM_ASSERT_SAME(a_no_step_at_zero, cmd.advance, !status.left_zero)
   `FPRM_ASSERT_SAME(a_no_result_overwrite, cmd.rsp_load, !rsp_valid || rsp_ready)
   `FPRM_ASSERT_NEXT(a_accept_then_rotate, req_valid && req_ready, cmd.rotate)
   `FPRM_ASSERT_NEXT(a_advance_then_measure, cmd.advance, cmd.measure)

endmodule

// File: dv/tb.sv
// Self-checking testbench for fixed_point_ray_march: a scoreboard predicts the steps left
// for every accepted ray and checks each response transaction against it.
// Depends on fprm_pkg and the fixed_point_ray_march RTL.
module tb;
   import fprm_pkg::*;

   localparam int RANDOM_RAYS = 1650;
   localparam int HOLD_CYCLES = 400;
   localparam int DRAIN_CYCLES = 80;
   localparam int LIMIT_CYCLES = 1_000_000;
   localparam int HALF_SHIFT = 16;
   localparam int PRINT_CAP = 40;

   typedef struct {
      logic signed [DIR_W-1:0] dx;
      logic signed [DIR_W-1:0] dy;
      logic signed [DIR_W-1:0] dz;
      logic [SL_W-1:0]         steps;
   } ray_steps_type;

   class march_scoreboard;
      logic signed [TRIG_W-1:0] sin_r;
      logic signed [TRIG_W-1:0] cos_r;
      logic [COORD_W-1:0]       org_r [3];
      ray_steps_type            pending_steps [$];
      int                       errors;

      function new();
         sin_r = '0;
         cos_r = ROT_COS_RESET;
         org_r = '{default: '0};
         errors = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [COORD_W-1:0] data);
         case (idx)
            CSR_ROT_SIN: sin_r = data[TRIG_W-1:0];
            CSR_ROT_COS: cos_r = data[TRIG_W-1:0];
            CSR_ORIGIN_X: org_r[0] = data;
            CSR_ORIGIN_Y: org_r[1] = data;
            CSR_ORIGIN_Z: org_r[2] = data;
            default: ;
         endcase
      endfunction

      function logic [SL_W-1:0] march_steps(logic signed [DIR_W-1:0] dx,
                                            logic signed [DIR_W-1:0] dy,
                                            logic signed [DIR_W-1:0] dz);
         longint             rx_sum;
         longint             rz_sum;
         logic [COORD_W-1:0] dir_v [3];
         logic [COORD_W-1:0] pos [3];
         logic [COORD_W-1:0] mag [3];
         int                 span;
         int                 left;
         rx_sum = (longint'(dx) * longint'(cos_r) + longint'(dz) * longint'(sin_r)) >>> FRAC_BITS;
         rz_sum = (longint'(dz) * longint'(cos_r) - longint'(dx) * longint'(sin_r)) >>> FRAC_BITS;
         dir_v[0] = rx_sum[COORD_W-1:0];
         dir_v[1] = {{(COORD_W-DIR_W){dy[DIR_W-1]}}, dy};
         dir_v[2] = rz_sum[COORD_W-1:0];
         pos = org_r;
         left = MAX_STEPS;
         while (left != 0) begin
            for (int i = 0; i < 3; i++) begin
               mag[i] = (pos[i] ^ {COORD_W{pos[i][COORD_W-1]}}) >> HALF_SHIFT;
            end
            span = int'(mag[0] | (mag[1] + mag[2])) - int'(DIST_BIAS);
            if (span < int'(HIT_LIMIT)) break;
            for (int i = 0; i < 3; i++) begin
               pos[i] = pos[i] + dir_v[i] * COORD_W'(span);
            end
            left--;
         end
         return SL_W'(left);
      endfunction

      function void note_ray(logic signed [DIR_W-1:0] dx, logic signed [DIR_W-1:0] dy,
                             logic signed [DIR_W-1:0] dz);
         ray_steps_type entry;
         entry.dx = dx;
         entry.dy = dy;
         entry.dz = dz;
         entry.steps = march_steps(dx, dy, dz);
         pending_steps.push_back(entry);
      endfunction

      task report(string what);
         errors++;
         if (errors <= PRINT_CAP) $display("ERROR at %0t: %s", $realtime, what);
      endtask

      task check_steps(logic [SL_W-1:0] got);
         ray_steps_type entry;
         if (pending_steps.size() == 0) begin
            report($sformatf("response transaction with steps_left %0d and no request", got));
         end else begin
            entry = pending_steps.pop_front();
            if (got !== entry.steps) begin
               report($sformatf("dir (%0d,%0d,%0d): steps_left %0d, predicted %0d",
                                entry.dx, entry.dy, entry.dz, got, entry.steps));
            end
         end
      endtask
   endclass

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   logic signed [DIR_W-1:0] req_dir_x = '0;
   logic signed [DIR_W-1:0] req_dir_y = '0;
   logic signed [DIR_W-1:0] req_dir_z = '0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   logic [SL_W-1:0]         rsp_steps_left;
   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   logic [CSR_IDX_W-1:0]    csr_index = '0;
   logic [COORD_W-1:0]      csr_wdata = '0;

   march_scoreboard sb;
   bit              gaps_on = 1'b1;
   bit              hold_pending = 1'b0;
   int              rays_sent = 0;

   fixed_point_ray_march uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_dir_x      (req_dir_x),
      .req_dir_y      (req_dir_y),
      .req_dir_z      (req_dir_z),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_steps_left (rsp_steps_left),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   initial begin
      #(LIMIT_CYCLES * 20);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   task automatic send_ray(input logic signed [DIR_W-1:0] dx, input logic signed [DIR_W-1:0] dy,
                           input logic signed [DIR_W-1:0] dz);
      int gap;
      gap = gaps_on ? $urandom_range(0, 3) : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_dir_x <= dx;
      req_dir_y <= dy;
      req_dir_z <= dz;
      do @(posedge clock); while (!req_ready);
      sb.note_ray(dx, dy, dz);
      rays_sent++;
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [COORD_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(idx, data);
   endtask

   task automatic load_config(input int s, input int c, input logic [COORD_W-1:0] ox,
                              input logic [COORD_W-1:0] oy, input logic [COORD_W-1:0] oz,
                              input bit unused_write);
      write_csr(CSR_ROT_SIN, s);
      write_csr(CSR_ROT_COS, c);
      write_csr(CSR_ORIGIN_X, ox);
      write_csr(CSR_ORIGIN_Y, oy);
      write_csr(CSR_ORIGIN_Z, oz);
      if (unused_write) begin
         write_csr(CSR_IDX_W'($urandom_range(CSR_ORIGIN_Z + 1, (1 << CSR_IDX_W) - 1)), $urandom);
      end
      csr_valid <= 1'b0;
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (sb.pending_steps.size() != 0) @(posedge clock);
   endtask

   function automatic int pick_trig(int style);
      int picks [5] = '{-8192, -4096, 0, 4096, 8191};
      case (style)
         0: return $urandom;
         1: return picks[$urandom_range(0, 4)];
         default: return int'($urandom_range(0, 8192)) - 4096;
      endcase
   endfunction

   function automatic logic [COORD_W-1:0] pick_coord(int style);
      logic [COORD_W-1:0] picks [4] = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF};
      logic [COORD_W-1:0] mag;
      mag = 32'h5000_0000 + $urandom_range(0, 32'h2FFF_FFFF);
      case (style)
         0: return $urandom;
         1: return picks[$urandom_range(0, 3)];
         default: begin
            case ($urandom_range(0, 2))
               0: return '0;
               1: return mag;
               default: return -mag;
            endcase
         end
      endcase
   endfunction

   function automatic logic signed [DIR_W-1:0] rand_dir();
      logic signed [DIR_W-1:0] v;
      v = DIR_W'($urandom);
      return v >>> $urandom_range(0, 12);
   endfunction

   initial begin
      int  stall;
      bit  held;
      held = 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         stall = gaps_on ? $urandom_range(0, 3) : 0;
         if (hold_pending && !held) begin
            held = 1'b1;
            stall = HOLD_CYCLES;
         end
         if (stall != 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         sb.check_steps(rsp_steps_left);
      end
   end

   initial begin
      int target;
      int phase;
      int style;
      int count;
      sb = new();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      send_ray(16'sh0000, 16'sh0000, 16'sh0000);
      send_ray(16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
      send_ray(16'sh8000, 16'sh8000, 16'sh8000);
      send_ray(16'shFFFF, 16'shFFFF, 16'shFFFF);
      settle();

      load_config(0, 4096, 32'h0, 32'h0, 32'hA000_0000, 1'b1);
      send_ray(16'sh0000, 16'sh0000, 16'sh7FFF);
      send_ray(16'sh0000, 16'sh0000, 16'sh4000);
      send_ray(16'sh0000, 16'sh0000, 16'sh0001);
      send_ray(16'sh0000, 16'sh0000, 16'sh8000);
      send_ray(16'sh0010, -16'sh0010, 16'sh0800);
      settle();

      load_config(-8192, 8191, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 1'b0);
      send_ray(16'sh7FFF, 16'sh0000, 16'sh8000);
      send_ray(16'sh8000, 16'sh7FFF, 16'sh7FFF);
      send_ray(16'sh8000, 16'sh8000, 16'sh8000);
      send_ray(16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
      send_ray(16'sh0000, 16'sh0001, 16'sh0000);
      settle();

      load_config(4096, -4096, 32'h6000_0000, 32'h0, 32'hE000_0000, 1'b0);
      send_ray(16'sh8000, 16'sh0000, 16'sh0000);
      send_ray(16'sh7FFF, 16'sh0000, 16'sh7FFF);
      send_ray(16'sh0001, 16'sh0001, 16'sh0001);
      send_ray(-16'sh0002, 16'sh0003, -16'sh0005);
      settle();

      target = rays_sent + RANDOM_RAYS;
      phase = 0;
      while (rays_sent < target) begin
         style = $urandom_range(0, 3);
         load_config(pick_trig(style), pick_trig(style), pick_coord(style), pick_coord(style),
                     pick_coord(style), $urandom_range(0, 3) == 0);
         gaps_on = ($urandom_range(0, 3) != 0);
         if (phase == 2) hold_pending = 1'b1;
         count = $urandom_range(60, 140);
         if (count > target - rays_sent) count = target - rays_sent;
         repeat (count) send_ray(rand_dir(), rand_dir(), rand_dir());
         settle();
         phase++;
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.pending_steps.size() != 0) begin
         sb.report($sformatf("%0d predicted results never arrived", sb.pending_steps.size()));
      end
      if (sb.errors == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
